>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication and next-cycle property checks used by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

>>> hdl/tpce_pkg.sv
// ----------------------------------------------------------------------------
// TCP passive connection engine package
// Shared codes and types.
// ----------------------------------------------------------------------------
package tpce_pkg;
    localparam logic [1:0] ACT_RECV  = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] KIND_HDR   = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_ESTAB = 3'd2;
    localparam logic [2:0] KIND_PFIN  = 3'd3;
    localparam logic [2:0] KIND_REL   = 3'd4;

    localparam logic [1:0] ST_SYNRCVD   = 2'd0;
    localparam logic [1:0] ST_ESTAB     = 2'd1;
    localparam logic [1:0] ST_CLOSEWAIT = 2'd2;
    localparam logic [1:0] ST_LASTACK   = 2'd3;

    localparam logic [8:0] FLAG_FIN = 9'h001;
    localparam logic [8:0] FLAG_SYN = 9'h002;
    localparam logic [8:0] FLAG_ACK = 9'h010;
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

    localparam logic [2:0] REG_PORT_A = 3'd0;
    localparam logic [2:0] REG_PORT_B = 3'd1;
    localparam logic [2:0] REG_PORT_C = 3'd2;
    localparam logic [2:0] REG_PORT_D = 3'd3;
    localparam logic [2:0] REG_LISTEN_EN = 3'd4;
    localparam logic [2:0] REG_ACCEPT = 3'd5;
    localparam logic [2:0] REG_AUTO_CLOSE = 3'd6;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] lport;
        logic [15:0] rport;
        logic [31:0] rip;
        logic [31:0] snd;
        logic [31:0] rcv;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [8:0]  flags;
        logic [15:0] plen;
    } result_t;

    typedef struct packed {
        logic [63:0] ports;
        logic [3:0]  enable;
        logic        accept_new;
        logic        auto_close;
    } cfg_t;
endpackage

>>> hdl/tpce_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file for listening ports and mode bits.
// ----------------------------------------------------------------------------
module tpce_regs import tpce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    logic [15:0] port_reg [4];
    logic [3:0]  en_reg;
    logic        acc_reg;
    logic        auto_reg;
    logic [2:0]  idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) port_reg[i] <= '0;
            en_reg   <= '0;
            acc_reg  <= 1'b1;
            auto_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_PORT_A, REG_PORT_B, REG_PORT_C, REG_PORT_D:
                    port_reg[idx[1:0]] <= pwdata[15:0];
                REG_LISTEN_EN:  en_reg   <= pwdata[3:0];
                REG_ACCEPT:     acc_reg  <= pwdata[0];
                REG_AUTO_CLOSE: auto_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PORT_A, REG_PORT_B, REG_PORT_C, REG_PORT_D:
                prdata = {16'd0, port_reg[idx[1:0]]};
            REG_LISTEN_EN:  prdata = {28'd0, en_reg};
            REG_ACCEPT:     prdata = {31'd0, acc_reg};
            REG_AUTO_CLOSE: prdata = {31'd0, auto_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.ports = {port_reg[3], port_reg[2], port_reg[1], port_reg[0]};
    assign cfg.enable = en_reg;
    assign cfg.accept_new = acc_reg;
    assign cfg.auto_close = auto_reg;
endmodule

>>> hdl/tpce_table.sv
// ----------------------------------------------------------------------------
// Connection table memory
// One-port synchronous RAM of entries, registered read data.
// ----------------------------------------------------------------------------
module tpce_table import tpce_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int AW = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  entry_t        wdata,
    output entry_t        rdata
);
    entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> hdl/tcp_passive_connection_engine.sv
// Flow: a received segment scans the table one entry a cycle, while send and
// close actions read their slot directly; results then leave one at a time,
// held while out_ready is low. A new item is taken only in idle, after the
// last item's results, as the single-port connection table is scanned in turn.
// Reset: rst_n clears all entry valid bits and control; no clearing pass.
// ----------------------------------------------------------------------------
// TCP passive connection engine
// Server-side connection table with handshake, data and close handling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tcp_passive_connection_engine import tpce_pkg::*;
#(
    parameter int CONN_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  slot,
    input  logic [31:0] peer_addr,
    input  logic [15:0] peer_port,
    input  logic [15:0] local_port,
    input  logic [31:0] seq_number,
    input  logic [31:0] ack_number,
    input  logic [8:0]  seg_flags,
    input  logic [3:0]  header_words,
    input  logic [15:0] segment_len,
    input  logic        checksum_ok,
    input  logic [31:0] initial_seq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [3:0]  out_slot,
    output logic [15:0] out_local_port,
    output logic [15:0] out_peer_port,
    output logic [31:0] out_peer_addr,
    output logic [31:0] out_seq,
    output logic [31:0] out_ack,
    output logic [8:0]  out_flags,
    output logic [15:0] payload_len,
    output logic        last
);
    localparam int AW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_RDSLT = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_DRAIN = 7'b1000000
    } fsm_t;

    cfg_t cfg;
    tpce_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    fsm_t          state_reg, state_next;
    logic [CONN_SLOTS-1:0] valid_reg;
    logic [AW:0]   cnt_reg;
    logic          found_reg;
    logic [AW-1:0] free_reg;
    logic          has_free_reg;

    // latched input item
    logic [1:0]  act_q;
    logic [31:0] rip_q, seq_q, ack_q, isn_q;
    logic [15:0] rport_q, lport_q, slen_q;
    logic [8:0]  flg_q;
    logic [15:0] plen_q;

    // result queue (up to four)
    result_t     res_reg [4];
    logic [2:0]  nres_reg;
    logic [1:0]  ridx_reg;
    entry_t      ent_reg;
    logic [AW-1:0] eslot_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    entry_t        ram_wdata, ram_rdata;

    tpce_table #(.SLOTS(CONN_SLOTS), .AW(AW)) u_table (
        .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [AW-1:0] cnt_idx;
    assign cnt_idx = cnt_reg[AW-1:0];

    logic [AW-1:0] slot_idx;
    assign slot_idx = AW'(slot);

    // previous scan address validity, registered to line up with the read data
    logic [AW:0]   rd_idx_reg;
    logic          rd_live_reg;

    logic hdr_ok;
    assign hdr_ok = (header_words >= MIN_HDR_WORDS) && checksum_ok
        && ({12'd0, header_words, 2'b00} <= {2'b0, segment_len});

    logic listening;
    always_comb
    begin
        listening = 1'b0;
        for (int i = 0; i < 4; i++)
            if (cfg.enable[i] && cfg.ports[i*16 +: 16] == lport_q)
                listening = 1'b1;
    end

    assign in_ready = (state_reg == S_IDLE);

    // evaluate of a received segment / app action on entry ent_reg
    result_t     r [4];
    logic [2:0]  nr;
    entry_t      wb;
    logic        do_wb;
    logic        set_v, clr_v;
    always_comb
    begin
        entry_t e;
        logic   stop;
        e = ent_reg;
        for (int i = 0; i < 4; i++) r[i] = '0;
        nr = '0;
        do_wb = 1'b0;
        set_v = 1'b0;
        clr_v = 1'b0;
        stop = 1'b0;
        if (act_q == ACT_RECV)
        begin
            if (!found_reg)
            begin
                if (flg_q[1] && listening && has_free_reg)
                begin
                    e.state = ST_SYNRCVD;
                    e.lport = lport_q;
                    e.rport = rport_q;
                    e.rip = rip_q;
                    e.rcv = seq_q + 32'd1;
                    e.snd = isn_q + 32'd1;
                    r[0] = '{KIND_HDR, isn_q, seq_q + 32'd1, FLAG_SYN | FLAG_ACK, 16'd0};
                    nr = 3'd1;
                    do_wb = 1'b1;
                    set_v = 1'b1;
                end
            end
            else
            begin
                if (e.state == ST_SYNRCVD)
                begin
                    if (flg_q[1])
                    begin
                        r[0] = '{KIND_HDR, e.snd - 32'd1, e.rcv, FLAG_SYN | FLAG_ACK, 16'd0};
                        nr = 3'd1;
                        stop = 1'b1;
                    end
                    else if (!flg_q[4] || e.snd != ack_q)
                        stop = 1'b1;
                    else if (!cfg.accept_new)
                    begin
                        r[0] = '{KIND_REL, 32'd0, 32'd0, 9'd0, 16'd0};
                        nr = 3'd1;
                        clr_v = 1'b1;
                        stop = 1'b1;
                    end
                    else
                    begin
                        e.state = ST_ESTAB;
                        r[0] = '{KIND_ESTAB, 32'd0, 32'd0, 9'd0, 16'd0};
                        nr = 3'd1;
                        do_wb = 1'b1;
                    end
                end
                if (!stop && e.state == ST_LASTACK)
                begin
                    if (flg_q[4])
                    begin
                        r[nr[1:0]] = '{KIND_REL, 32'd0, 32'd0, 9'd0, 16'd0};
                        nr = nr + 3'd1;
                        clr_v = 1'b1;
                    end
                    stop = 1'b1;
                end
                if (!stop)
                begin
                    if (plen_q != 16'd0)
                    begin
                        e.rcv = e.rcv + {16'd0, plen_q};
                        r[nr[1:0]] = '{KIND_DATA, 32'd0, 32'd0, 9'd0, plen_q};
                        nr = nr + 3'd1;
                        do_wb = 1'b1;
                    end
                    if (flg_q[0])
                    begin
                        e.rcv = e.rcv + 32'd1;
                        r[nr[1:0]] = '{KIND_HDR, e.snd, e.rcv, FLAG_ACK, 16'd0};
                        nr = nr + 3'd1;
                        e.state = ST_CLOSEWAIT;
                        do_wb = 1'b1;
                        if (cfg.auto_close)
                        begin
                            r[nr[1:0]] = '{KIND_HDR, e.snd, e.rcv, FLAG_FIN | FLAG_ACK, 16'd0};
                            nr = nr + 3'd1;
                            e.snd = e.snd + 32'd1;
                            e.state = ST_LASTACK;
                        end
                        else
                        begin
                            r[nr[1:0]] = '{KIND_PFIN, 32'd0, 32'd0, 9'd0, 16'd0};
                            nr = nr + 3'd1;
                        end
                    end
                end
            end
        end
        else if (found_reg)
        begin
            if (act_q == ACT_SEND)
            begin
                if (e.state == ST_ESTAB || e.state == ST_CLOSEWAIT)
                begin
                    r[0] = '{KIND_HDR, e.snd, e.rcv, FLAG_ACK, slen_q};
                    nr = 3'd1;
                    e.snd = e.snd + {16'd0, slen_q};
                    do_wb = 1'b1;
                end
            end
            else if (act_q == ACT_CLOSE)
            begin
                if (e.state != ST_LASTACK)
                begin
                    r[0] = '{KIND_HDR, e.snd, e.rcv, FLAG_FIN | FLAG_ACK, 16'd0};
                    nr = 3'd1;
                    e.snd = e.snd + 32'd1;
                    e.state = ST_LASTACK;
                    do_wb = 1'b1;
                end
            end
        end
        wb = e;
    end

    // table port usage
    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = wb;
        ram_addr = eslot_reg;
        priority case (state_reg)
            S_IDLE:  ram_addr = slot_idx;
            S_SCAN:  ram_addr = cnt_idx;
            // a hit on the last scanned entry is not in eslot_reg yet
            S_WAIT:  ram_addr = found_reg ? eslot_reg : rd_idx_reg[AW-1:0];
            S_EVAL:  ram_we = do_wb;
            default: ram_addr = eslot_reg;
        endcase
    end

    logic entry_match;
    assign entry_match = rd_live_reg && valid_reg[rd_idx_reg[AW-1:0]]
        && ram_rdata.lport == lport_q && ram_rdata.rip == rip_q
        && ram_rdata.rport == rport_q;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (action == ACT_RECV)
                        state_next = hdr_ok ? S_SCAN : S_IDLE;
                    else if (action == ACT_SEND || action == ACT_CLOSE)
                        state_next = S_RDSLT;
                end
            S_SCAN:  if (cnt_reg == (AW+1)'(CONN_SLOTS - 1) || entry_match)
                         state_next = S_WAIT;
            S_WAIT:  state_next = (found_reg || entry_match) ? S_RDSLT : S_EVAL;
            S_RDSLT: state_next = S_EVAL;
            S_EVAL:  state_next = (nr != 3'd0) ? S_EMIT : S_DRAIN;
            S_EMIT:  if (out_ready && ridx_reg == 2'(nres_reg - 3'd1))
                         state_next = S_DRAIN;
            S_DRAIN: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            has_free_reg <= 1'b0;
            free_reg <= '0;
            rd_live_reg <= 1'b0;
            rd_idx_reg <= '0;
            eslot_reg <= '0;
            ent_reg <= '0;
            for (int i = 0; i < 4; i++) res_reg[i] <= '0;
            nres_reg <= '0;
            ridx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_live_reg <= (state_reg == S_SCAN) && !entry_match;
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    has_free_reg <= 1'b0;
                    ridx_reg <= '0;
                    eslot_reg <= slot_idx;
                    found_reg <= (action == ACT_SEND || action == ACT_CLOSE)
                        && (int'(slot) < CONN_SLOTS) && valid_reg[slot_idx];
                end
                S_SCAN:
                begin
                    rd_idx_reg <= cnt_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!has_free_reg && !valid_reg[cnt_idx])
                    begin
                        has_free_reg <= 1'b1;
                        free_reg <= cnt_idx;
                    end
                    if (entry_match)
                    begin
                        found_reg <= 1'b1;
                        eslot_reg <= rd_idx_reg[AW-1:0];
                    end
                end
                S_WAIT:
                begin
                    if (entry_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        eslot_reg <= rd_idx_reg[AW-1:0];
                    end
                    else if (!found_reg)
                        eslot_reg <= free_reg;
                end
                S_RDSLT: ent_reg <= ram_rdata;
                S_EVAL:
                begin
                    for (int i = 0; i < 4; i++) res_reg[i] <= r[i];
                    nres_reg <= nr;
                    if (set_v) valid_reg[eslot_reg] <= 1'b1;
                    if (clr_v) valid_reg[eslot_reg] <= 1'b0;
                    ent_reg <= wb;
                end
                S_EMIT:  if (out_ready) ridx_reg <= ridx_reg + 2'd1;
                S_DRAIN: ;
                default: ;
            endcase
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            act_q <= action;
            rip_q <= peer_addr;
            rport_q <= peer_port;
            lport_q <= local_port;
            seq_q <= seq_number;
            ack_q <= ack_number;
            flg_q <= seg_flags;
            slen_q <= segment_len;
            isn_q <= initial_seq;
            plen_q <= segment_len - {10'd0, header_words, 2'b00};
        end
    end

    // result fields: the entry after update holds port/address for all results
    result_t cur;
    assign cur = res_reg[ridx_reg];
    assign out_valid = (state_reg == S_EMIT);
    assign kind = cur.kind;
    assign out_slot = 4'(eslot_reg);
    assign out_local_port = ent_reg.lport;
    assign out_peer_port = ent_reg.rport;
    assign out_peer_addr = ent_reg.rip;
    assign out_seq = cur.seq;
    assign out_ack = cur.ack;
    assign out_flags = cur.flags;
    assign payload_len = cur.plen;
    assign last = (ridx_reg == 2'(nres_reg - 3'd1));

    `ASSERT_IMPLIES(a_out_idle, clk, rst_n, out_valid, !in_ready)
    `ASSERT_IMPLIES(a_nres, clk, rst_n, out_valid, nres_reg != 3'd0 && nres_reg <= 3'd4)
    `ASSERT_NEXT(a_emit_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMPLIES(a_setclr, clk, rst_n, state_reg == S_EVAL, !(set_v && clr_v))
endmodule
